// File: src/point_to_glyph_hit_test_unit_assert.svh
// Assertion macros for the hit test unit
`ifndef POINT_TO_GLYPH_HIT_TEST_UNIT_ASSERT_SVH
`define POINT_TO_GLYPH_HIT_TEST_UNIT_ASSERT_SVH

// same-cycle implication
`define PTG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ptg_pkg.sv
`default_nettype none
package ptg_pkg;

    localparam int PTG_MAX_BOXES = 1024;
    localparam int COST_W        = 21;
    localparam int IDX_W         = 10;
    localparam int Y_WEIGHT      = 15;

    localparam logic [COST_W-1:0] COST_RESET = 21'd100000;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [11:0]        w;
        logic [11:0]        h;
        logic               srch;
    } box_t;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [COST_W-1:0] cost;
    } eval_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } seq_state_t;

endpackage
`default_nettype wire

// File: src/ptg_ram.sv
`default_nettype none
module ptg_ram #(
    parameter int WIDTH = 57,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: src/ptg_eval.sv
`default_nettype none
module ptg_eval
    import ptg_pkg::*;
#(
    parameter int IW = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               flush,
    input  wire logic               in_valid,
    input  wire logic [IW-1:0]      in_idx,
    input  wire box_t               in_box,
    input  wire logic signed [15:0] px,
    input  wire logic signed [15:0] py,
    output eval_res_t               res,
    output logic [IW-1:0]           res_idx,
    output logic                    busy
);

    // stage 1: containment and signed center offsets
    logic signed [16:0] x17, y17, xe, ye, cx, cy, px17, py17;
    logic signed [17:0] dxs, dys;
    logic               hit1;

    logic               v1_reg, hit1_reg;
    logic signed [17:0] dxs_reg, dys_reg;
    logic [IW-1:0]      idx1_reg;

    // stage 2: magnitudes
    logic [17:0]        adx, ady;
    logic               v2_reg, hit2_reg;
    logic [16:0]        dx_reg, dy_reg;
    logic [IW-1:0]      idx2_reg;

    // stage 3: weighted cost
    logic [COST_W-1:0]  cost;
    logic               v3_reg, hit3_reg;
    logic [COST_W-1:0]  cost_reg;
    logic [IW-1:0]      idx3_reg;

    always_comb
    begin
        x17  = $signed({in_box.x[15], in_box.x});
        y17  = $signed({in_box.y[15], in_box.y});
        px17 = $signed({px[15], px});
        py17 = $signed({py[15], py});
        xe   = x17 + $signed({5'b0, in_box.w});
        ye   = y17 + $signed({5'b0, in_box.h});
        cx   = x17 + $signed({6'b0, in_box.w[11:1]});
        cy   = y17 + $signed({6'b0, in_box.h[11:1]});
        hit1 = (px17 >= x17) && (px17 < xe) && (py17 >= y17) && (py17 < ye);
        dxs  = $signed({cx[16], cx}) - $signed({px17[16], px17});
        dys  = $signed({cy[16], cy}) - $signed({py17[16], py17});
        adx  = dxs_reg[17] ? 18'(-dxs_reg) : 18'(dxs_reg);
        ady  = dys_reg[17] ? 18'(-dys_reg) : 18'(dys_reg);
        cost = COST_W'(dx_reg) + COST_W'(dy_reg) * COST_W'(Y_WEIGHT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (flush)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid && in_box.srch;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hit1_reg <= hit1;
        dxs_reg  <= dxs;
        dys_reg  <= dys;
        idx1_reg <= in_idx;
        hit2_reg <= hit1_reg;
        dx_reg   <= adx[16:0];
        dy_reg   <= ady[16:0];
        idx2_reg <= idx1_reg;
        hit3_reg <= hit2_reg;
        cost_reg <= cost;
        idx3_reg <= idx2_reg;
    end

    assign res.valid = v3_reg;
    assign res.hit   = hit3_reg;
    assign res.cost  = cost_reg;
    assign res_idx   = idx3_reg;
    assign busy      = v1_reg || v2_reg || v3_reg;

endmodule
`default_nettype wire

// File: src/point_to_glyph_hit_test_unit.sv
// Clear and append leave busy low, so one may follow every cycle.
// A query reads one stored box per cycle into the evaluation pipeline and drives done once the
// list is scanned and the pipeline drained, or early after an exact hit; an empty list skips the scan.
// busy falls as done rises, so a new beat can be taken while done is high.
// The receiver cannot stall the result; done is high for one cycle.
// Reset (rst_n low, asynchronous) empties the list and sets max_cost to 100000.
`default_nettype none
module point_to_glyph_hit_test_unit
    import ptg_pkg::*;
#(
    parameter int MAX_BOXES = PTG_MAX_BOXES
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         mode,
    input  wire logic signed [15:0] box_x,
    input  wire logic signed [15:0] box_y,
    input  wire logic [11:0]        box_w,
    input  wire logic [11:0]        box_h,
    input  wire logic               searchable,
    input  wire logic signed [15:0] point_x,
    input  wire logic signed [15:0] point_y,
    input  wire logic               cfg_we,
    input  wire logic [COST_W-1:0]  cfg_wdata,
    output logic                    done,
    output logic                    found,
    output logic                    exact_hit,
    output logic [IDX_W-1:0]        box_index
);

    localparam int AW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int EW = (AW > IDX_W) ? AW : IDX_W;

    seq_state_t state_reg, state_next;

    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      addr_reg, addr_next;
    logic [COST_W-1:0]  max_cost_reg;
    logic [COST_W-1:0]  best_reg, best_next;
    logic               near_reg, near_next;
    logic               exact_reg, exact_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic signed [15:0] px_reg, px_next, py_reg, py_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    logic               done_reg, done_next;
    logic               found_reg, found_next;
    logic               exact_out_reg, exact_out_next;
    logic [IDX_W-1:0]   bidx_reg, bidx_next;

    logic               we, issue, flush, eval_busy;
    box_t               wbox, rbox;
    logic [$bits(box_t)-1:0] rdata;
    eval_res_t          res;
    logic [AW-1:0]      res_idx;
    logic [EW-1:0]      idx_ext;

    assign wbox = '{x: box_x, y: box_y, w: box_w, h: box_h, srch: searchable};
    assign rbox = box_t'(rdata);

    ptg_ram #(
        .WIDTH ($bits(box_t)),
        .DEPTH (MAX_BOXES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wbox),
        .raddr (addr_reg[AW-1:0]),
        .rdata (rdata)
    );

    ptg_eval #(
        .IW (AW)
    ) u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .flush    (flush),
        .in_valid (rd_valid_reg),
        .in_idx   (rd_idx_reg),
        .in_box   (rbox),
        .px       (px_reg),
        .py       (py_reg),
        .res      (res),
        .res_idx  (res_idx),
        .busy     (eval_busy)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        best_next      = best_reg;
        near_next      = near_reg;
        exact_next     = exact_reg;
        idx_next       = idx_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        rd_valid_next  = 1'b0;
        rd_idx_next    = addr_reg[AW-1:0];
        done_next      = 1'b0;
        found_next     = found_reg;
        exact_out_next = exact_out_reg;
        bidx_next      = bidx_reg;
        we             = 1'b0;
        issue          = 1'b0;
        flush          = 1'b0;
        idx_ext        = EW'(idx_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (mode)
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        MODE_APPEND:
                        begin
                            if (count_reg < CW'(MAX_BOXES))
                            begin
                                we         = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_QUERY:
                        begin
                            px_next    = point_x;
                            py_next    = point_y;
                            best_next  = max_cost_reg;
                            near_next  = 1'b0;
                            exact_next = 1'b0;
                            idx_next   = '0;
                            addr_next  = '0;
                            state_next = (count_reg == '0) ? ST_FINISH : ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN, ST_DRAIN:
            begin
                if (res.valid && res.hit)
                begin
                    exact_next = 1'b1;
                    idx_next   = res_idx;
                    flush      = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    if (res.valid && (res.cost < best_reg))
                    begin
                        best_next = res.cost;
                        near_next = 1'b1;
                        idx_next  = res_idx;
                    end
                    if (state_reg == ST_SCAN)
                    begin
                        issue         = 1'b1;
                        rd_valid_next = 1'b1;
                        addr_next     = addr_reg + 1'b1;
                        if (addr_next == count_reg)
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                    else if (!rd_valid_reg && !eval_busy)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                flush          = 1'b1;
                done_next      = 1'b1;
                found_next     = exact_reg || near_reg;
                exact_out_next = exact_reg;
                bidx_next      = (exact_reg || near_reg) ? idx_ext[IDX_W-1:0] : '0;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (flush || !issue)
        begin
            rd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            max_cost_reg  <= COST_RESET;
            rd_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            exact_out_reg <= 1'b0;
            bidx_reg      <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_valid_reg  <= rd_valid_next;
            done_reg      <= done_next;
            found_reg     <= found_next;
            exact_out_reg <= exact_out_next;
            bidx_reg      <= bidx_next;
            if (cfg_we)
            begin
                max_cost_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        best_reg   <= best_next;
        near_reg   <= near_next;
        exact_reg  <= exact_next;
        idx_reg    <= idx_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        rd_idx_reg <= rd_idx_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign found     = found_reg;
    assign exact_hit = exact_out_reg;
    assign box_index = bidx_reg;

endmodule
`default_nettype wire

// File: src/ptg_checker.sv
`default_nettype none
`include "point_to_glyph_hit_test_unit_assert.svh"
module ptg_checker
    import ptg_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic [1:0]       mode,
    input wire logic             done,
    input wire logic             found,
    input wire logic             exact_hit,
    input wire logic [IDX_W-1:0] box_index
);

    `PTG_ASSERT_NOW(a_exact_found, done && exact_hit, found, "exact hit without found")
    `PTG_ASSERT_NOW(a_miss_index, done && !found, box_index == '0, "miss with nonzero index")
    `PTG_ASSERT_NEXT(a_query_busy, start && !busy && (mode == MODE_QUERY), busy,
        "query beat did not raise busy")
    `PTG_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
    `PTG_ASSERT_NEXT(a_list_op, start && !busy && (mode == MODE_CLEAR || mode == MODE_APPEND),
        !busy && !done, "list beat stalled or produced a result")

endmodule

bind point_to_glyph_hit_test_unit ptg_checker u_ptg_checker (.*);
`default_nettype wire

// File: bench/point_to_glyph_hit_test_unit_checker.sv
`timescale 1ns / 1ps
module point_to_glyph_hit_test_unit_checker
    import ptg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [1:0]         mode,
    input  wire logic signed [15:0] box_x,
    input  wire logic signed [15:0] box_y,
    input  wire logic [11:0]        box_w,
    input  wire logic [11:0]        box_h,
    input  wire logic               searchable,
    input  wire logic signed [15:0] point_x,
    input  wire logic signed [15:0] point_y,
    input  wire logic               cfg_we,
    input  wire logic [COST_W-1:0]  cfg_wdata,
    input  wire logic               done,
    input  wire logic               found,
    input  wire logic               exact_hit,
    input  wire logic [IDX_W-1:0]   box_index,
    output int                      fail_count,
    output int                      outstanding
);

    typedef struct packed {
        logic             found;
        logic             exact;
        logic [IDX_W-1:0] idx;
    } pick_t;

    box_t              glyph_list [PTG_MAX_BOXES];
    int                glyph_total;
    logic [COST_W-1:0] cost_limit;
    pick_t             pick_queue [$];
    pick_t             want;
    int                mismatches;

    function automatic pick_t predict_pick(input logic signed [15:0] qx,
                                           input logic signed [15:0] qy);
        pick_t p;
        int    i;
        int    px;
        int    py;
        int    bx;
        int    by;
        int    bw;
        int    bh;
        int    dx;
        int    dy;
        int    cost;
        int    best;
        p  = '0;
        px = qx;
        py = qy;
        for (i = 0; i < glyph_total && !p.found; i++)
        begin
            bx = $signed(glyph_list[i].x);
            by = $signed(glyph_list[i].y);
            bw = glyph_list[i].w;
            bh = glyph_list[i].h;
            if (glyph_list[i].srch && px >= bx && px < bx + bw && py >= by && py < by + bh)
            begin
                p.found = 1'b1;
                p.exact = 1'b1;
                p.idx   = i[IDX_W-1:0];
            end
        end
        if (!p.found)
        begin
            best = int'(cost_limit);
            for (i = 0; i < glyph_total; i++)
            begin
                if (glyph_list[i].srch)
                begin
                    bx = $signed(glyph_list[i].x);
                    by = $signed(glyph_list[i].y);
                    bw = glyph_list[i].w;
                    bh = glyph_list[i].h;
                    dx = bx + bw / 2 - px;
                    dy = by + bh / 2 - py;
                    if (dx < 0)
                        dx = -dx;
                    if (dy < 0)
                        dy = -dy;
                    cost = dx + Y_WEIGHT * dy;
                    if (cost < best)
                    begin
                        best    = cost;
                        p.found = 1'b1;
                        p.idx   = i[IDX_W-1:0];
                    end
                end
            end
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_total = 0;
            cost_limit  = COST_RESET;
            pick_queue.delete();
            mismatches  = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pick_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: found=%0d exact_hit=%0d box_index=%0d",
                                 found, exact_hit, box_index);
                end
                else
                begin
                    want = pick_queue.pop_front();
                    if (want.found !== found || want.exact !== exact_hit ||
                        want.idx !== box_index)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: expected found=%0d exact=%0d index=%0d",
                                     want.found, want.exact, want.idx);
                            $display("          actual   found=%0d exact=%0d index=%0d",
                                     found, exact_hit, box_index);
                        end
                    end
                end
            end
            if (cfg_we)
                cost_limit = cfg_wdata;
            if (start && !busy)
            begin
                case (mode)
                    MODE_CLEAR:
                        glyph_total = 0;
                    MODE_APPEND:
                        if (glyph_total < PTG_MAX_BOXES)
                        begin
                            glyph_list[glyph_total] = '{x: box_x, y: box_y, w: box_w,
                                                        h: box_h, srch: searchable};
                            glyph_total++;
                        end
                    MODE_QUERY:
                        pick_queue.push_back(predict_pick(point_x, point_y));
                    default:
                        ;
                endcase
            end
            fail_count  <= mismatches;
            outstanding <= pick_queue.size();
        end
    end

endmodule

// File: bench/point_to_glyph_hit_test_unit_test.sv
`timescale 1ns / 1ps
module point_to_glyph_hit_test_unit_test;
    import ptg_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               start      = 1'b0;
    logic [1:0]         mode       = MODE_CLEAR;
    logic signed [15:0] box_x      = '0;
    logic signed [15:0] box_y      = '0;
    logic [11:0]        box_w      = '0;
    logic [11:0]        box_h      = '0;
    logic               searchable = 1'b0;
    logic signed [15:0] point_x    = '0;
    logic signed [15:0] point_y    = '0;
    logic               cfg_we     = 1'b0;
    logic [COST_W-1:0]  cfg_wdata  = '0;
    wire                busy;
    wire                done;
    wire                found;
    wire                exact_hit;
    wire [IDX_W-1:0]    box_index;
    int                 fail_count;
    int                 outstanding;

    bit gaps_on = 1'b1;
    int aim_x [16];
    int aim_y [16];
    int aim_w [16];
    int aim_h [16];
    int aim_n;
    int aim_next;
    int rand_items;
    int next_phase;
    int phase;
    int region_x;
    int region_y;
    int n_boxes;
    int n_queries;

    always #1 clk = ~clk;

    point_to_glyph_hit_test_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .box_x      (box_x),
        .box_y      (box_y),
        .box_w      (box_w),
        .box_h      (box_h),
        .searchable (searchable),
        .point_x    (point_x),
        .point_y    (point_y),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .found      (found),
        .exact_hit  (exact_hit),
        .box_index  (box_index)
    );

    point_to_glyph_hit_test_unit_checker watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .box_x       (box_x),
        .box_y       (box_y),
        .box_w       (box_w),
        .box_h       (box_h),
        .searchable  (searchable),
        .point_x     (point_x),
        .point_y     (point_y),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .found       (found),
        .exact_hit   (exact_hit),
        .box_index   (box_index),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // start stays high until the beat is taken
    task automatic put_item(input logic [1:0] m, input int bx, input int by, input int bw,
                            input int bh, input bit s, input int qx, input int qy);
        if (gaps_on && $urandom_range(99) < 24)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start      <= 1'b1;
        mode       <= m;
        box_x      <= bx[15:0];
        box_y      <= by[15:0];
        box_w      <= bw[11:0];
        box_h      <= bh[11:0];
        searchable <= s;
        point_x    <= qx[15:0];
        point_y    <= qy[15:0];
        do @(posedge clk); while (busy);
    endtask

    task automatic append_box(input int bx, input int by, input int bw, input int bh,
                              input bit s);
        put_item(MODE_APPEND, bx, by, bw, bh, s, $urandom, $urandom);
        aim_x[aim_next] = $signed(bx[15:0]);
        aim_y[aim_next] = $signed(by[15:0]);
        aim_w[aim_next] = bw[11:0];
        aim_h[aim_next] = bh[11:0];
        aim_next = (aim_next + 1) % 16;
        if (aim_n < 16)
            aim_n++;
    endtask

    task automatic query_at(input int qx, input int qy);
        put_item(MODE_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                 qx, qy);
    endtask

    task automatic clear_list();
        put_item(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                 $urandom, $urandom);
        aim_n    = 0;
        aim_next = 0;
    endtask

    task automatic send_noise();
        put_item(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                 $urandom, $urandom);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic set_cost(input int v);
        drain();
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[COST_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_box();
        int bx;
        int by;
        int bw;
        int bh;
        bit s;
        if ($urandom_range(99) < 15)
        begin
            bx = $urandom;
            by = $urandom;
            bw = $urandom;
            bh = $urandom;
            s  = $urandom_range(0, 1);
        end
        else
        begin
            bx = region_x + int'($urandom_range(0, 1500));
            by = region_y + int'($urandom_range(0, 400));
            bw = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 300));
            bh = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 60));
            s  = $urandom_range(99) < 85;
        end
        append_box(bx, by, bw, bh, s);
    endtask

    task automatic random_query();
        int k;
        int r;
        int qx;
        int qy;
        r = $urandom_range(99);
        k = (aim_n > 0) ? int'($urandom_range(0, aim_n - 1)) : 0;
        if (aim_n > 0 && r < 45)
        begin
            qx = aim_x[k] + ((aim_w[k] > 0) ? int'($urandom_range(0, aim_w[k] - 1)) : 0);
            qy = aim_y[k] + ((aim_h[k] > 0) ? int'($urandom_range(0, aim_h[k] - 1)) : 0);
        end
        else if (aim_n > 0 && r < 75)
        begin
            qx = aim_x[k] + aim_w[k] / 2 + int'($urandom_range(0, 400)) - 200;
            qy = aim_y[k] + aim_h[k] / 2 + int'($urandom_range(0, 40)) - 20;
        end
        else
        begin
            qx = $urandom;
            qy = $urandom;
        end
        query_at(qx, qy);
    endtask

    initial
    begin
        #1_000_000;
        $display("point_to_glyph_hit_test_unit_test NOT OK");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed, reset limit
        query_at(0, 0);
        append_box(0, 0, 0, 0, 1'b1);
        query_at(0, 0);
        append_box(-32768, -32768, 4095, 4095, 1'b1);
        query_at(-32768, -32768);
        query_at(-28674, -28674);
        query_at(-28673, -28673);
        append_box(32767, 32767, 4095, 4095, 1'b0);
        query_at(32767, 32767);
        append_box(32767, 32767, 4095, 4095, 1'b1);
        query_at(32767, 32767);
        send_noise();
        append_box(100, 100, 10, 10, 1'b1);
        append_box(100, 100, 10, 10, 1'b1);
        query_at(105, 105);
        append_box(200, 0, 0, 0, 1'b1);
        append_box(190, 0, 20, 0, 1'b1);
        query_at(200, 5);
        query_at(-32768, 32767);
        query_at(32767, -32768);
        clear_list();
        query_at(0, 0);
        append_box(10, 10, 50, 50, 1'b0);
        query_at(20, 20);
        send_noise();

        set_cost(0);
        append_box(500, 500, 20, 20, 1'b1);
        query_at(505, 505);
        query_at(600, 600);
        set_cost(2097151);
        query_at(-32768, -32768);

        // full list, last two appends dropped
        set_cost(0);
        clear_list();
        for (int i = 0; i < PTG_MAX_BOXES - 1; i++)
            append_box(-20000 + int'($urandom_range(0, 3000)),
                       -20000 + int'($urandom_range(0, 3000)),
                       $urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 1));
        append_box(30000, 30000, 50, 50, 1'b1);
        append_box(32000, 32000, 100, 100, 1'b1);
        append_box(32000, 32000, 100, 100, 1'b1);
        query_at(32050, 32050);
        query_at(30010, 30010);
        query_at(-19000, -19000);
        set_cost(2097151);
        query_at(32050, 32050);
        query_at($urandom, $urandom);

        set_cost(COST_RESET);
        clear_list();
        rand_items = 0;
        next_phase = 30;
        phase      = 0;
        while (rand_items < 190)
        begin
            if (rand_items >= next_phase)
            begin
                case (phase % 6)
                    0: set_cost(0);
                    1: set_cost(2097151);
                    2: set_cost($urandom_range(0, 2097151));
                    3: set_cost(COST_RESET);
                    4: set_cost($urandom_range(1, 3000));
                    default: set_cost(1);
                endcase
                phase++;
                next_phase += 30;
            end
            gaps_on  = !(rand_items >= 60 && rand_items < 130);
            region_x = int'($urandom_range(0, 58000)) - 30000;
            region_y = int'($urandom_range(0, 62000)) - 31000;
            if ($urandom_range(99) < 80)
            begin
                clear_list();
                rand_items++;
            end
            if ($urandom_range(99) < 10)
            begin
                random_query();
                rand_items++;
            end
            n_boxes = ($urandom_range(99) < 8) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            for (int j = 0; j < n_boxes; j++)
            begin
                random_box();
                rand_items++;
                if ($urandom_range(99) < 12)
                begin
                    random_query();
                    rand_items++;
                end
                if ($urandom_range(99) < 4)
                    send_noise();
            end
            n_queries = $urandom_range(1, 5);
            for (int j = 0; j < n_queries; j++)
            begin
                random_query();
                rand_items++;
            end
            if ($urandom_range(99) < 3)
                drain();
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("point_to_glyph_hit_test_unit_test OK");
        else
            $display("point_to_glyph_hit_test_unit_test NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/ptg_pkg.sv
src/ptg_ram.sv
src/ptg_eval.sv
src/point_to_glyph_hit_test_unit.sv
src/ptg_checker.sv
bench/point_to_glyph_hit_test_unit_checker.sv
bench/point_to_glyph_hit_test_unit_test.sv
